// ===== sv/fsc_pkg.sv =====
package fsc_pkg;

   localparam int NumPlanesDef = 6;
   localparam int CoordW = 32;
   localparam int TolW = 16;
   localparam int ProdW = 2 * CoordW;
   localparam int AccW = ProdW + 2;
   localparam int OffW = CoordW + 2;
   localparam int ReqDataW = 232;
   localparam int ReqUserW = 3;
   localparam int RspDataW = 8;

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_POINT = 3'd1;
   localparam logic [2:0] MODE_SPHERE = 3'd2;
   localparam logic [2:0] MODE_OVERLAP = 3'd3;
   localparam logic [2:0] MODE_CONTAIN = 3'd4;

   localparam logic [1:0] STEP_X = 2'd0;
   localparam logic [1:0] STEP_Y = 2'd1;
   localparam logic [1:0] STEP_Z = 2'd2;
   localparam logic [1:0] STEP_CHECK = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [CoordW-1:0] nx;
      logic signed [CoordW-1:0] ny;
      logic signed [CoordW-1:0] nz;
      logic signed [CoordW-1:0] d;
   } plane_type;

   typedef struct packed {
      logic init;
      logic accum;
   } mac_ctrl_type;

endpackage

// ===== sv/fsc_plane_store.sv =====
module fsc_plane_store #(
   parameter int NUM_PLANES = fsc_pkg::NumPlanesDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] wr_slot,
   input  fsc_pkg::plane_type  wr_plane,
   input  logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] rd_slot,
   output fsc_pkg::plane_type  rd_plane
);

   fsc_pkg::plane_type table_ff [NUM_PLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            table_ff[i] <= '0;
         end
      end else if (wr_en) begin
         table_ff[wr_slot] <= wr_plane;
      end
   end

   assign rd_plane = table_ff[rd_slot];

endmodule

// ===== sv/fsc_mac.sv =====
module fsc_mac (
   input  logic                               clock,
   input  fsc_pkg::mac_ctrl_type              ctrl,
   input  logic signed [fsc_pkg::CoordW-1:0]  op_a,
   input  logic signed [fsc_pkg::CoordW-1:0]  op_b,
   input  logic signed [fsc_pkg::AccW-1:0]    init_val,
   output logic                               sum_neg
);

   logic signed [fsc_pkg::ProdW-1:0] prod_ff;
   logic signed [fsc_pkg::ProdW-1:0] prod_in;
   logic signed [fsc_pkg::AccW-1:0]  acc_ff;
   logic signed [fsc_pkg::AccW-1:0]  acc_in;
   logic signed [fsc_pkg::AccW-1:0]  sum;

   always_comb begin
      prod_in = op_a * op_b;
      sum = acc_ff + {{2{prod_ff[fsc_pkg::ProdW-1]}}, prod_ff};
      if (ctrl.init) begin
         acc_in = init_val;
      end else if (ctrl.accum) begin
         acc_in = sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign sum_neg = sum[fsc_pkg::AccW-1];

endmodule

// ===== sv/frustum_cull_tester_core.sv =====
// Load requests are accepted while idle and return nothing.
// A test request runs on the one shared multiply-accumulate unit (four steps per
// plane), then posts the verdict; no new request is accepted until the verdict is
// posted, and a response that is not yet taken holds the core in ST_DONE.
// Synchronous reset clears the plane table, the tolerance and the FSM control state.
module frustum_cull_tester_core #(
   parameter int NUM_PLANES = fsc_pkg::NumPlanesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // plane_slot[2:0], first_x, first_y, first_z, second_x, second_y, second_z,
   // scalar (32 bits each from bit 3), zero pad [231:227]
   input  logic [fsc_pkg::ReqDataW-1:0]  req_tdata,
   // mode[2:0]
   input  logic [fsc_pkg::ReqUserW-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // visible[0], zero pad [7:1]
   output logic [fsc_pkg::RspDataW-1:0]  rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fsc_pkg::TolW-1:0]      csr_data
);

   localparam int PlaneW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int CW = fsc_pkg::CoordW;

   fsc_pkg::state_type state_ff, state_in;
   logic [PlaneW-1:0] plane_ff, plane_in;
   logic [1:0] step_ff, step_in;
   logic pass_ff, pass_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_vis_ff, rsp_vis_in;
   logic [fsc_pkg::TolW-1:0] tol_ff, tol_in;
   logic [2:0] mode_ff, mode_in;
   logic signed [CW-1:0] fx_ff, fy_ff, fz_ff, sx_ff, sy_ff, sz_ff, sc_ff;
   logic signed [CW-1:0] fx_in, fy_in, fz_in, sx_in, sy_in, sz_in, sc_in;

   logic [2:0] req_mode, req_slot;
   logic signed [CW-1:0] r_fx, r_fy, r_fz, r_sx, r_sy, r_sz, r_sc;
   logic req_fire;

   fsc_pkg::plane_type wr_plane, rd_plane;
   logic wr_en;
   fsc_pkg::mac_ctrl_type mac_ctrl;
   logic signed [CW-1:0] op_a, op_b, vert_f, vert_s;
   logic use_second;
   logic signed [fsc_pkg::OffW-1:0] off_sum;
   logic signed [fsc_pkg::AccW-1:0] init_val;
   logic sum_neg;

   assign req_mode = req_tuser[2:0];
   assign req_slot = req_tdata[2:0];
   assign r_fx = req_tdata[3 +: CW];
   assign r_fy = req_tdata[3 + CW +: CW];
   assign r_fz = req_tdata[3 + 2 * CW +: CW];
   assign r_sx = req_tdata[3 + 3 * CW +: CW];
   assign r_sy = req_tdata[3 + 4 * CW +: CW];
   assign r_sz = req_tdata[3 + 5 * CW +: CW];
   assign r_sc = req_tdata[3 + 6 * CW +: CW];

   assign req_tready = !reset && (state_ff == fsc_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(fsc_pkg::RspDataW - 1){1'b0}}, rsp_vis_ff};

   assign wr_en = req_fire && (req_mode == fsc_pkg::MODE_LOAD)
                  && (32'(req_slot) < NUM_PLANES);
   assign wr_plane = '{nx: r_fx, ny: r_fy, nz: r_fz, d: r_sc};

   fsc_plane_store #(
      .NUM_PLANES(NUM_PLANES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_slot  (req_slot[PlaneW-1:0]),
      .wr_plane (wr_plane),
      .rd_slot  (plane_ff),
      .rd_plane (rd_plane)
   );

   always_comb begin
      case (step_ff)
         fsc_pkg::STEP_Y: begin
            op_a = rd_plane.ny;
            vert_f = fy_ff;
            vert_s = sy_ff;
         end
         fsc_pkg::STEP_Z: begin
            op_a = rd_plane.nz;
            vert_f = fz_ff;
            vert_s = sz_ff;
         end
         default: begin
            op_a = rd_plane.nx;
            vert_f = fx_ff;
            vert_s = sx_ff;
         end
      endcase
      use_second = ((mode_ff == fsc_pkg::MODE_OVERLAP) && !op_a[CW-1])
                   || ((mode_ff == fsc_pkg::MODE_CONTAIN) && op_a[CW-1]);
      op_b = use_second ? vert_s : vert_f;
      off_sum = {{2{rd_plane.d[CW-1]}}, rd_plane.d}
                + ((mode_ff == fsc_pkg::MODE_SPHERE) ? {{2{sc_ff[CW-1]}}, sc_ff}
                                                     : {fsc_pkg::OffW{1'b0}})
                + {{(fsc_pkg::OffW - fsc_pkg::TolW){1'b0}}, tol_ff};
      init_val = {{16{off_sum[fsc_pkg::OffW-1]}}, off_sum, 16'd0};
   end

   fsc_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_a     (op_a),
      .op_b     (op_b),
      .init_val (init_val),
      .sum_neg  (sum_neg)
   );

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      step_in = step_ff;
      pass_in = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_vis_in = rsp_vis_ff;
      tol_in = csr_valid ? csr_data : tol_ff;
      mode_in = mode_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      fz_in = fz_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sz_in = sz_ff;
      sc_in = sc_ff;
      mac_ctrl.init = (state_ff == fsc_pkg::ST_RUN) && (step_ff == fsc_pkg::STEP_X);
      mac_ctrl.accum = (state_ff == fsc_pkg::ST_RUN) && (step_ff != fsc_pkg::STEP_X);
      case (state_ff)
         fsc_pkg::ST_IDLE: begin
            if (req_fire && (req_mode >= fsc_pkg::MODE_POINT)
                && (req_mode <= fsc_pkg::MODE_CONTAIN)) begin
               state_in = fsc_pkg::ST_RUN;
               plane_in = '0;
               step_in = fsc_pkg::STEP_X;
               pass_in = 1'b1;
               mode_in = req_mode;
               fx_in = r_fx;
               fy_in = r_fy;
               fz_in = r_fz;
               sx_in = r_sx;
               sy_in = r_sy;
               sz_in = r_sz;
               sc_in = r_sc;
            end
         end
         fsc_pkg::ST_RUN: begin
            step_in = step_ff + 2'd1;
            if (step_ff == fsc_pkg::STEP_CHECK) begin
               pass_in = pass_ff && !sum_neg;
               if (plane_ff == PlaneW'(NUM_PLANES - 1)) begin
                  state_in = fsc_pkg::ST_DONE;
               end else begin
                  plane_in = plane_ff + PlaneW'(1);
               end
            end
         end
         fsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in = pass_ff;
               state_in = fsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsc_pkg::ST_IDLE;
         plane_ff <= '0;
         step_ff <= fsc_pkg::STEP_X;
         pass_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         tol_ff <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         step_ff <= step_in;
         pass_ff <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vis_ff <= rsp_vis_in;
      mode_ff <= mode_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fz_ff <= fz_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
      sc_ff <= sc_in;
   end

endmodule

// ===== tb/frustum_cull_checker.sv =====
`timescale 1ns / 100ps

module frustum_cull_checker #(
   parameter int NUM_PLANES = fsc_pkg::NumPlanesDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [fsc_pkg::ReqDataW-1:0] req_tdata,
   input  logic [fsc_pkg::ReqUserW-1:0] req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [fsc_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [fsc_pkg::TolW-1:0]     csr_data,
   output int                           error_count,
   output int                           verdicts_pending
);

   fsc_pkg::plane_type       planes [NUM_PLANES];
   logic [fsc_pkg::TolW-1:0] tolerance;
   bit                       verdicts [$];
   int                       errs;
   logic [2:0]               mode;
   logic [2:0]               slot;
   logic signed [31:0]       fx, fy, fz, sx, sy, sz, sc;
   bit                       wanted;

   // exact signed distance plus slack, Q32.32 in 128 bits
   function automatic bit in_front(fsc_pkg::plane_type pl, logic signed [31:0] px,
                                   logic signed [31:0] py, logic signed [31:0] pz,
                                   longint slack);
      logic signed [127:0] nx, ny, nz, d, vx, vy, vz, s, total;
      nx = $signed(pl.nx);
      ny = $signed(pl.ny);
      nz = $signed(pl.nz);
      d = $signed(pl.d);
      vx = px;
      vy = py;
      vz = pz;
      s = slack;
      total = nx * vx + ny * vy + nz * vz + (d + s) * 128'sd65536;
      return !total[127];
   endfunction

   function automatic bit visible_against_all(logic [2:0] op,
                                              logic signed [31:0] ax, logic signed [31:0] ay,
                                              logic signed [31:0] az, logic signed [31:0] bx,
                                              logic signed [31:0] by, logic signed [31:0] bz,
                                              logic signed [31:0] rad);
      bit                 seen;
      longint             slack;
      logic signed [31:0] vx, vy, vz;
      seen = 1'b1;
      for (int i = 0; i < NUM_PLANES; i++) begin
         vx = ax;
         vy = ay;
         vz = az;
         slack = longint'(tolerance);
         case (op)
            fsc_pkg::MODE_SPHERE: slack = slack + longint'(rad);
            fsc_pkg::MODE_OVERLAP: begin
               if (!planes[i].nx[31]) vx = bx;
               if (!planes[i].ny[31]) vy = by;
               if (!planes[i].nz[31]) vz = bz;
            end
            fsc_pkg::MODE_CONTAIN: begin
               if (planes[i].nx[31]) vx = bx;
               if (planes[i].ny[31]) vy = by;
               if (planes[i].nz[31]) vz = bz;
            end
            default: ;
         endcase
         if (!in_front(planes[i], vx, vy, vz, slack)) seen = 1'b0;
      end
      return seen;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (planes[i]) planes[i] = '0;
         tolerance = '0;
         verdicts.delete();
         errs = 0;
      end else begin
         if (csr_valid && csr_ready) tolerance = csr_data;
         if (req_tvalid && req_tready) begin
            mode = req_tuser[2:0];
            slot = req_tdata[2:0];
            fx = req_tdata[3 +: 32];
            fy = req_tdata[35 +: 32];
            fz = req_tdata[67 +: 32];
            sx = req_tdata[99 +: 32];
            sy = req_tdata[131 +: 32];
            sz = req_tdata[163 +: 32];
            sc = req_tdata[195 +: 32];
            if (mode == fsc_pkg::MODE_LOAD) begin
               if (slot < NUM_PLANES) planes[slot] = '{fx, fy, fz, sc};
            end else if (mode <= fsc_pkg::MODE_CONTAIN) begin
               verdicts.push_back(visible_against_all(mode, fx, fy, fz, sx, sy, sz, sc));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts.size() == 0) begin
               $error("visible: expected none, actual %0d", rsp_tdata[0]);
               errs++;
            end else begin
               wanted = verdicts.pop_front();
               if (rsp_tdata[0] !== wanted) begin
                  $error("visible: expected %0d, actual %0d", wanted, rsp_tdata[0]);
                  errs++;
               end
            end
         end
      end
      error_count <= errs;
      verdicts_pending <= verdicts.size();
   end

endmodule

// ===== tb/frustum_cull_tester_core_tb.sv =====
`timescale 1ns / 100ps

module frustum_cull_tester_core_tb;

   localparam int Unit = 65536;
   localparam int Wall = 10 * Unit;
   localparam int PerPhase = 230;
   localparam int SettleCycles = 32;
   localparam int HoldCycles = 400;
   localparam int CycleLimit = 1000000;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [fsc_pkg::ReqDataW-1:0] req_tdata;
   logic [fsc_pkg::ReqUserW-1:0] req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [fsc_pkg::RspDataW-1:0] rsp_tdata;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [fsc_pkg::TolW-1:0]     csr_data;

   int fail_count;
   int verdicts_pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int hold_done = 0;
   int items_sent = 0;
   int cycle_count = 0;

   frustum_cull_tester_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   frustum_cull_checker verdict_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (fail_count),
      .verdicts_pending(verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      forever begin
         if (hold_asks != hold_done) begin
            hold_done++;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
            @(posedge clock);
         end
      end
   end

   task automatic issue(input logic [2:0] mode, input logic [2:0] slot,
                        input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz,
                        input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
                        input logic [31:0] sc);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'b0, sc, sz, sy, sx, fz, fy, fx, slot};
      do @(posedge clock); while (!req_tready);
      if (mode <= fsc_pkg::MODE_CONTAIN) items_sent++;
   endtask

   // axis-aligned wall: even slots face +axis, odd slots face -axis
   task automatic load_wall(input logic [2:0] slot, input logic [31:0] offset);
      logic [31:0] n;
      n = slot[0] ? -Unit : Unit;
      issue(fsc_pkg::MODE_LOAD, slot, (slot[2:1] == 2'd0) ? n : 32'd0,
            (slot[2:1] == 2'd1) ? n : 32'd0, (slot[2:1] == 2'd2) ? n : 32'd0,
            $urandom(), $urandom(), $urandom(), offset);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (verdicts_pending == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [fsc_pkg::TolW-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      logic [31:0] c;
      case ($urandom_range(7))
         0: c = $urandom();
         1: begin
            case ($urandom_range(3))
               0: c = 32'h7fff_ffff;
               1: c = 32'h8000_0000;
               2: c = '0;
               default: c = '1;
            endcase
         end
         2, 3: begin
            c = Wall + $urandom_range(2 * Unit) - Unit;
            if ($urandom_range(1)) c = -c;
         end
         default: c = $urandom_range(40 * Unit) - 20 * Unit;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] pick_normal();
      case ($urandom_range(4))
         0: return '0;
         1: return Unit;
         2: return -Unit;
         3: return $urandom_range(4 * Unit) - 2 * Unit;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int          target;
      int          pick;
      logic [2:0]  mode;
      logic [31:0] fx, fy, fz, sx, sy, sz, sc;
      logic [fsc_pkg::TolW-1:0] tol;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue(fsc_pkg::MODE_POINT, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '1, '1, '1, '1);
      for (int s = 0; s < fsc_pkg::NumPlanesDef; s++) load_wall(3'(s), Wall);
      issue(fsc_pkg::MODE_LOAD, 3'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
            32'h8000_0000);
      issue(fsc_pkg::MODE_LOAD, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0,
            32'h8000_0000);
      for (int m = fsc_pkg::MODE_CONTAIN + 1; m < 8; m++)
         issue(3'(m), 3'd0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
      issue(fsc_pkg::MODE_POINT, 3'd0, 0, 0, 0, 0, 0, 0, 0);
      issue(fsc_pkg::MODE_POINT, 3'd0, Wall, 0, 0, 0, 0, 0, 0);
      issue(fsc_pkg::MODE_POINT, 3'd0, Wall + 1, 0, 0, 0, 0, 0, 0);
      issue(fsc_pkg::MODE_POINT, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 0, 0, 0);
      issue(fsc_pkg::MODE_SPHERE, 3'd0, Wall + 2 * Unit, 0, 0, 0, 0, 0, 2 * Unit);
      issue(fsc_pkg::MODE_SPHERE, 3'd0, Wall + 2 * Unit, 0, 0, 0, 0, 0, 2 * Unit - 1);
      issue(fsc_pkg::MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, -(Wall + Unit));
      issue(fsc_pkg::MODE_OVERLAP, 3'd0, -20 * Unit, -20 * Unit, -20 * Unit, -15 * Unit,
            0, 0, 0);
      issue(fsc_pkg::MODE_OVERLAP, 3'd0, -20 * Unit, -20 * Unit, -20 * Unit, 20 * Unit,
            20 * Unit, 20 * Unit, 0);
      issue(fsc_pkg::MODE_OVERLAP, 3'd0, 5 * Unit, 5 * Unit, 5 * Unit, -5 * Unit, -5 * Unit,
            -5 * Unit, 0);
      issue(fsc_pkg::MODE_CONTAIN, 3'd0, -5 * Unit, -5 * Unit, -5 * Unit, 5 * Unit, 5 * Unit,
            5 * Unit, 0);
      issue(fsc_pkg::MODE_CONTAIN, 3'd0, -20 * Unit, -20 * Unit, -20 * Unit, 20 * Unit,
            20 * Unit, 20 * Unit, 0);
      issue(fsc_pkg::MODE_LOAD, 3'd5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0,
            32'h7fff_ffff);
      issue(fsc_pkg::MODE_POINT, 3'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            0, 0, 0, 0);
      issue(fsc_pkg::MODE_CONTAIN, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);

      for (int sub = 0; sub < 8; sub++) begin
         drain();
         case (sub / 2)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         case (sub)
            0, 6: tol = '1;
            1: tol = '0;
            3: tol = 16'd1;
            4: tol = 16'h8000;
            default: tol = 16'($urandom());
         endcase
         write_tolerance(tol);
         if (sub == 1) hold_asks++;
         for (int s = 0; s < fsc_pkg::NumPlanesDef; s++) load_wall(3'(s), Wall);
         target = items_sent + PerPhase;
         while (items_sent < target) begin
            fx = pick_coord();
            fy = pick_coord();
            fz = pick_coord();
            sx = $urandom();
            sy = $urandom();
            sz = $urandom();
            sc = $urandom();
            pick = $urandom_range(99);
            if (pick < 3) begin
               issue(3'(fsc_pkg::MODE_CONTAIN + 1 + $urandom_range(2)), 3'($urandom()),
                     fx, fy, fz, sx, sy, sz, sc);
            end else if (pick < 9) begin
               load_wall(3'($urandom_range(7)), Wall + $urandom_range(2 * Unit) - Unit);
            end else if (pick < 13) begin
               issue(fsc_pkg::MODE_LOAD, 3'($urandom()), pick_normal(), pick_normal(),
                     pick_normal(), sx, sy, sz, pick_coord());
            end else begin
               mode = 3'(fsc_pkg::MODE_POINT + $urandom_range(3));
               if (mode == fsc_pkg::MODE_SPHERE) begin
                  case ($urandom_range(5))
                     0: sc = $urandom();
                     1: sc = -$urandom_range(Unit);
                     default: sc = $urandom_range(3 * Unit);
                  endcase
               end
               if (mode >= fsc_pkg::MODE_OVERLAP && $urandom_range(3) != 0) begin
                  sx = fx + $urandom_range(6 * Unit);
                  sy = fy + $urandom_range(6 * Unit);
                  sz = fz + $urandom_range(6 * Unit);
               end
               issue(mode, 3'($urandom()), fx, fy, fz, sx, sy, sz, sc);
            end
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== frustum_cull_tester_core.f =====
sv/fsc_pkg.sv
sv/fsc_plane_store.sv
sv/fsc_mac.sv
sv/frustum_cull_tester_core.sv
tb/frustum_cull_checker.sv
tb/frustum_cull_tester_core_tb.sv
